FILE: hdl/ipd_pkg.sv
// Package for the pulse-distance infrared decoder.
// Holds the configuration and result types, register indexes, reset values and key mapping.
// No dependencies.
package ipd_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned EDGE_W = 8;
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned KEY_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEADER_MIN = 4'd0,
        REG_LEADER_MAX = 4'd1,
        REG_ZERO_LOW   = 4'd2,
        REG_ZERO_HIGH  = 4'd3,
        REG_ONE_LOW    = 4'd4,
        REG_ONE_HIGH   = 4'd5,
        REG_TIMEOUT    = 4'd6,
        REG_CUSTOMER   = 4'd7
    } ipd_reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0] LEADER_MIN_RST = 16'd127;
    localparam logic [TICK_W-1:0] LEADER_MAX_RST = 16'd140;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 16'd9;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 16'd14;
    localparam logic [TICK_W-1:0] ONE_LOW_RST    = 16'd19;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 16'd25;
    localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd1500;
    localparam logic [TICK_W-1:0] CUSTOMER_RST   = 16'h80bf;

    // Edge number at which a complete frame is checked.
    localparam logic [EDGE_W-1:0] CHECK_EDGE = 8'd34;
    localparam logic [EDGE_W-1:0] EDGE_START = 8'd1;
    localparam logic [EDGE_W-1:0] EDGE_LEADER = 8'd2;

    // Command codes of the mapped keys.
    localparam logic [CODE_W-1:0] CODE_MENU   = 8'h6b;
    localparam logic [CODE_W-1:0] CODE_UP     = 8'h53;
    localparam logic [CODE_W-1:0] CODE_DOWN   = 8'h4b;
    localparam logic [CODE_W-1:0] CODE_LEFT   = 8'h99;
    localparam logic [CODE_W-1:0] CODE_RIGHT  = 8'h83;
    localparam logic [CODE_W-1:0] CODE_ENTER  = 8'h73;
    localparam logic [CODE_W-1:0] CODE_CANCEL = 8'ha3;

    typedef enum logic [KEY_W-1:0] {
        KEY_NONE   = 3'd0,
        KEY_MENU   = 3'd1,
        KEY_UP     = 3'd2,
        KEY_DOWN   = 3'd3,
        KEY_LEFT   = 3'd4,
        KEY_RIGHT  = 3'd5,
        KEY_ENTER  = 3'd6,
        KEY_CANCEL = 3'd7
    } ipd_key_t;

    typedef struct packed {
        logic [TICK_W-1:0] leader_min;
        logic [TICK_W-1:0] leader_max;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] timeout;
        logic [TICK_W-1:0] customer;
    } ipd_cfg_t;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] raw_code;
        logic [KEY_W-1:0]  key_id;
    } ipd_result_t;

    // Map a validated command byte to a key number.
    function automatic ipd_key_t map_key(input logic [CODE_W-1:0] code);
        ipd_key_t key;
        unique case (code)
            CODE_MENU:   key = KEY_MENU;
            CODE_UP:     key = KEY_UP;
            CODE_DOWN:   key = KEY_DOWN;
            CODE_LEFT:   key = KEY_LEFT;
            CODE_RIGHT:  key = KEY_RIGHT;
            CODE_ENTER:  key = KEY_ENTER;
            CODE_CANCEL: key = KEY_CANCEL;
            default:     key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

FILE: hdl/ipd_cfg_regs.sv
// Configuration register file of the pulse-distance infrared decoder.
// Depends on ipd_pkg for the register indexes, reset values and ipd_cfg_t.
module ipd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipd_pkg::TICK_W-1:0]    cfg_data,
    output ipd_pkg::ipd_cfg_t             cfg
);

    ipd_pkg::ipd_cfg_t cfg_reg;
    ipd_pkg::ipd_cfg_t cfg_next;

    // Decode the write; unknown indexes leave every register unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ipd_pkg::REG_LEADER_MIN: cfg_next.leader_min = cfg_data;
                ipd_pkg::REG_LEADER_MAX: cfg_next.leader_max = cfg_data;
                ipd_pkg::REG_ZERO_LOW:   cfg_next.zero_low   = cfg_data;
                ipd_pkg::REG_ZERO_HIGH:  cfg_next.zero_high  = cfg_data;
                ipd_pkg::REG_ONE_LOW:    cfg_next.one_low    = cfg_data;
                ipd_pkg::REG_ONE_HIGH:   cfg_next.one_high   = cfg_data;
                ipd_pkg::REG_TIMEOUT:    cfg_next.timeout    = cfg_data;
                ipd_pkg::REG_CUSTOMER:   cfg_next.customer   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_min <= ipd_pkg::LEADER_MIN_RST;
            cfg_reg.leader_max <= ipd_pkg::LEADER_MAX_RST;
            cfg_reg.zero_low   <= ipd_pkg::ZERO_LOW_RST;
            cfg_reg.zero_high  <= ipd_pkg::ZERO_HIGH_RST;
            cfg_reg.one_low    <= ipd_pkg::ONE_LOW_RST;
            cfg_reg.one_high   <= ipd_pkg::ONE_HIGH_RST;
            cfg_reg.timeout    <= ipd_pkg::TIMEOUT_RST;
            cfg_reg.customer   <= ipd_pkg::CUSTOMER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ipd_frame.sv
// Frame receiver of the pulse-distance infrared decoder: edge counter, bit shifter and check.
// Depends on ipd_pkg for ipd_cfg_t, ipd_result_t, the frame constants and map_key.
module ipd_frame (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [ipd_pkg::TICK_W-1:0] gap,
    input  ipd_pkg::ipd_cfg_t          cfg,
    output ipd_pkg::ipd_result_t       result
);

    logic [ipd_pkg::EDGE_W-1:0]  edge_count_reg;
    logic [ipd_pkg::EDGE_W-1:0]  edge_count_next;
    logic [ipd_pkg::FRAME_W-1:0] frame_bits_reg;
    logic [ipd_pkg::FRAME_W-1:0] frame_bits_next;

    logic [ipd_pkg::EDGE_W-1:0]  edge_base;
    logic [ipd_pkg::EDGE_W-1:0]  edge_inc;
    logic [ipd_pkg::FRAME_W-1:0] shifted;
    logic                        leader_ok;
    logic                        zero_hit;
    logic                        one_hit;
    logic [ipd_pkg::CODE_W-1:0]  cmd;
    logic [ipd_pkg::CODE_W-1:0]  cpl;
    logic                        frame_ok;

    // Gap classification against the configured windows.
    assign edge_base = (gap > cfg.timeout) ? '0 : edge_count_reg;
    assign edge_inc  = edge_base + ipd_pkg::EDGE_W'(1);
    assign leader_ok = (gap >= cfg.leader_min) && (gap <= cfg.leader_max);
    assign zero_hit  = (gap > cfg.zero_low) && (gap < cfg.zero_high);
    assign one_hit   = (gap > cfg.one_low) && (gap < cfg.one_high);

    // The zero window has priority where the windows overlap.
    assign shifted = {frame_bits_reg[ipd_pkg::FRAME_W-2:0], !zero_hit};

    // Frame check on the word that includes the bit of this edge.
    assign cmd      = shifted[15:8];
    assign cpl      = shifted[7:0];
    assign frame_ok = (shifted[31:16] == cfg.customer) && (~cpl == cmd)
                      && (cmd != '0);

    // Next state and result for one edge.
    always_comb
    begin
        edge_count_next = edge_count_reg;
        frame_bits_next = frame_bits_reg;
        result.hit      = 1'b0;
        result.raw_code = cmd;
        result.key_id   = ipd_pkg::map_key(cmd);
        if (advance)
        begin
            priority if (edge_inc == ipd_pkg::EDGE_START)
            begin
                edge_count_next = edge_inc;
                frame_bits_next = '0;
            end
            else if (edge_inc == ipd_pkg::EDGE_LEADER)
            begin
                edge_count_next = leader_ok ? edge_inc : '0;
            end
            else if (!zero_hit && !one_hit)
            begin
                // A bad bit gap restarts the frame and shifts nothing in.
                edge_count_next = '0;
            end
            else
            begin
                edge_count_next = edge_inc;
                frame_bits_next = shifted;
                result.hit      = (edge_inc == ipd_pkg::CHECK_EDGE) && frame_ok;
            end
        end
    end

    // Receiver state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            frame_bits_reg <= '0;
        end
        else
        begin
            edge_count_reg <= edge_count_next;
            frame_bits_reg <= frame_bits_next;
        end
    end

endmodule

FILE: hdl/ir_pulse_distance_decoder.sv
// Top level of the pulse-distance infrared decoder: input register, frame receiver, result register.
// Depends on ipd_pkg, ipd_cfg_regs and ipd_frame.

// Each transfer on the input channel is one receiver edge with the timer ticks since the edge
// before it. An edge is taken into an input register and handled, once it may advance, in one
// pass through the frame receiver, which updates the edge counter and the 32-bit frame word and,
// on the check edge of a frame whose customer code and command complement check out and whose
// command byte is nonzero, loads one result into the output register. The block accepts one
// edge per cycle; a stalled result holds the pipeline only when the input register is also full,
// so an edge is still taken while a finished result waits. The result goes from the input
// register through the frame receiver into the output register. Configuration registers are
// written through a plain write port and take effect at once; write them only while no edge
// is in flight.
module ir_pulse_distance_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipd_pkg::TICK_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ipd_pkg::TICK_W-1:0]    gap_ticks,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ipd_pkg::CODE_W-1:0]    raw_code,
    output logic [ipd_pkg::KEY_W-1:0]     key_id
);

    ipd_pkg::ipd_cfg_t    cfg;
    ipd_pkg::ipd_result_t result;

    logic                       in_valid_reg;
    logic [ipd_pkg::TICK_W-1:0] gap_reg;
    logic                       out_valid_reg;
    logic [ipd_pkg::CODE_W-1:0] raw_code_reg;
    logic [ipd_pkg::KEY_W-1:0]  key_id_reg;
    logic                       advance;

    // The held edge moves on whenever the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    ipd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipd_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .gap     (gap_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Control of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= result.hit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            gap_reg <= gap_ticks;
        end
        if (advance && result.hit)
        begin
            raw_code_reg <= result.raw_code;
            key_id_reg   <= result.key_id;
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_code  = raw_code_reg;
    assign key_id    = key_id_reg;

    // A delivered result always carries a nonzero command byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> raw_code != '0)
        else $error("result offered with a zero command byte");

    // The input side only stalls when both pipeline registers are full and output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && in_valid_reg))
        else $error("input stalled while the pipeline could move");

    // An accepted edge is held in the input register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_valid_reg)
        else $error("accepted edge lost from the input register");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pulse-distance infrared decoder.
// It drives receiver edges and register writes, predicts each decoded key press and checks it.
// Depends on ipd_pkg and ir_pulse_distance_decoder.
module testbench;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_EDGES = 200;
    localparam int PHASE_KEYS = 3;
    localparam int UNITS_PER_SETTING = 4;
    localparam int NO_BREAK = -1;
    localparam int TICK_MAX = (1 << ipd_pkg::TICK_W) - 1;
    localparam logic [ipd_pkg::TICK_W-1:0] GAP_MAX = '1;
    localparam int WRAP_EDGES = (1 << ipd_pkg::EDGE_W) - int'(ipd_pkg::CHECK_EDGE);

    // One decoded key press as the output channel presents it.
    typedef struct packed {
        logic [ipd_pkg::CODE_W-1:0] code;
        ipd_pkg::ipd_key_t          key;
    } key_press_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ipd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ipd_pkg::TICK_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [ipd_pkg::TICK_W-1:0]    gap_ticks = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [ipd_pkg::CODE_W-1:0]    raw_code;
    logic [ipd_pkg::KEY_W-1:0]     key_id;

    // Mirror of the register file and of the receiver state.
    ipd_pkg::ipd_cfg_t           cfg_now;
    logic [ipd_pkg::EDGE_W-1:0]  edge_cnt = '0;
    logic [ipd_pkg::FRAME_W-1:0] frame_word = '0;
    key_press_t                  key_queue[$];

    int send_idle_pct = 13;
    int recv_idle_pct = 83;
    int edges_sent = 0;
    int keys_predicted = 0;
    int errors = 0;
    int quiet_cycles = 0;

    ir_pulse_distance_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .gap_ticks (gap_ticks),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .raw_code  (raw_code),
        .key_id    (key_id)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Compare every result transfer with the oldest predicted key press, then pick the next stall.
    always @(posedge clk)
    begin : check_results
        key_press_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (key_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got raw_code %h key_id %0d",
                         $time, raw_code, key_id);
            end
            else
            begin
                want = key_queue.pop_front();
                if (raw_code !== want.code)
                begin
                    errors++;
                    $display("%0t: raw_code expected %h, got %h", $time, want.code, raw_code);
                end
                if (key_id !== want.key)
                begin
                    errors++;
                    $display("%0t: key_id expected %0d, got %0d", $time, want.key, key_id);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // End the run when no transfer happens on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic ipd_pkg::ipd_cfg_t reset_config();
        ipd_pkg::ipd_cfg_t c;
        c.leader_min = ipd_pkg::LEADER_MIN_RST;
        c.leader_max = ipd_pkg::LEADER_MAX_RST;
        c.zero_low = ipd_pkg::ZERO_LOW_RST;
        c.zero_high = ipd_pkg::ZERO_HIGH_RST;
        c.one_low = ipd_pkg::ONE_LOW_RST;
        c.one_high = ipd_pkg::ONE_HIGH_RST;
        c.timeout = ipd_pkg::TIMEOUT_RST;
        c.customer = ipd_pkg::CUSTOMER_RST;
        return c;
    endfunction

    // Sane windows in increasing order, sometimes shifted high, sometimes with overlapping
    // bit windows, and now and then a timeout that can never fire.
    function automatic ipd_pkg::ipd_cfg_t random_config();
        ipd_pkg::ipd_cfg_t c;
        int base;
        base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 30000)) : 0;
        c.zero_low = ipd_pkg::TICK_W'(base + int'($urandom_range(0, 40)));
        c.zero_high = c.zero_low + ipd_pkg::TICK_W'($urandom_range(2, 12));
        if ($urandom_range(0, 4) == 0)
            c.one_low = c.zero_low + ipd_pkg::TICK_W'($urandom_range(0, 6));
        else
            c.one_low = c.zero_high + ipd_pkg::TICK_W'($urandom_range(0, 10));
        c.one_high = c.one_low + ipd_pkg::TICK_W'($urandom_range(2, 12));
        c.leader_min = c.one_high + ipd_pkg::TICK_W'($urandom_range(0, 200));
        c.leader_max = c.leader_min + ipd_pkg::TICK_W'($urandom_range(0, 30));
        if ($urandom_range(0, 7) == 0)
            c.timeout = GAP_MAX;
        else
            c.timeout = c.leader_max + ipd_pkg::TICK_W'($urandom_range(0, 3000));
        c.customer = ipd_pkg::TICK_W'($urandom_range(0, TICK_MAX));
        return c;
    endfunction

    function automatic ipd_pkg::ipd_key_t key_for(input logic [ipd_pkg::CODE_W-1:0] code);
        ipd_pkg::ipd_key_t key;
        case (code)
            ipd_pkg::CODE_MENU:   key = ipd_pkg::KEY_MENU;
            ipd_pkg::CODE_UP:     key = ipd_pkg::KEY_UP;
            ipd_pkg::CODE_DOWN:   key = ipd_pkg::KEY_DOWN;
            ipd_pkg::CODE_LEFT:   key = ipd_pkg::KEY_LEFT;
            ipd_pkg::CODE_RIGHT:  key = ipd_pkg::KEY_RIGHT;
            ipd_pkg::CODE_ENTER:  key = ipd_pkg::KEY_ENTER;
            ipd_pkg::CODE_CANCEL: key = ipd_pkg::KEY_CANCEL;
            default:              key = ipd_pkg::KEY_NONE;
        endcase
        return key;
    endfunction

    function automatic logic [ipd_pkg::CODE_W-1:0] random_key_code();
        logic [ipd_pkg::CODE_W-1:0] code;
        case ($urandom_range(0, 6))
            0:       code = ipd_pkg::CODE_MENU;
            1:       code = ipd_pkg::CODE_UP;
            2:       code = ipd_pkg::CODE_DOWN;
            3:       code = ipd_pkg::CODE_LEFT;
            4:       code = ipd_pkg::CODE_RIGHT;
            5:       code = ipd_pkg::CODE_ENTER;
            default: code = ipd_pkg::CODE_CANCEL;
        endcase
        return code;
    endfunction

    // A random gap in [lo, hi]; when the window is empty, any gap at all.
    function automatic logic [ipd_pkg::TICK_W-1:0] gap_in(input int lo, input int hi);
        if (lo > hi)
            return ipd_pkg::TICK_W'($urandom_range(0, TICK_MAX));
        return ipd_pkg::TICK_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [ipd_pkg::TICK_W-1:0] bit_gap(input logic one);
        if (one)
            return gap_in(int'(cfg_now.one_low) + 1, int'(cfg_now.one_high) - 1);
        return gap_in(int'(cfg_now.zero_low) + 1, int'(cfg_now.zero_high) - 1);
    endfunction

    function automatic logic [ipd_pkg::TICK_W-1:0] leader_gap();
        return gap_in(int'(cfg_now.leader_min), int'(cfg_now.leader_max));
    endfunction

    function automatic logic [ipd_pkg::TICK_W-1:0] restart_gap();
        return gap_in(int'(cfg_now.timeout) + 1, TICK_MAX);
    endfunction

    // Customer code, command byte and its complement.
    function automatic logic [ipd_pkg::FRAME_W-1:0] good_word(
        input logic [ipd_pkg::CODE_W-1:0] cmd);
        return {cfg_now.customer, cmd, ~cmd};
    endfunction

    // Advance the receiver mirror by one edge and queue the key press it completes, if any.
    task automatic track_edge(input logic [ipd_pkg::TICK_W-1:0] gap);
        logic       in_zero;
        logic       in_one;
        key_press_t press;
        in_zero = (gap > cfg_now.zero_low) && (gap < cfg_now.zero_high);
        in_one = (gap > cfg_now.one_low) && (gap < cfg_now.one_high);
        if (gap > cfg_now.timeout)
            edge_cnt = '0;
        edge_cnt = edge_cnt + ipd_pkg::EDGE_W'(1);
        if (edge_cnt == ipd_pkg::EDGE_START)
        begin
            frame_word = '0;
        end
        else if (edge_cnt == ipd_pkg::EDGE_LEADER)
        begin
            if (gap < cfg_now.leader_min || gap > cfg_now.leader_max)
                edge_cnt = '0;
        end
        else if (!in_zero && !in_one)
        begin
            edge_cnt = '0;
        end
        else
        begin
            // The zero window wins where the two windows overlap.
            frame_word = {frame_word[ipd_pkg::FRAME_W-2:0], !in_zero};
            press.code = frame_word[15:8];
            press.key = key_for(press.code);
            if (edge_cnt == ipd_pkg::CHECK_EDGE && frame_word[31:16] == cfg_now.customer
                && press.code == ~frame_word[7:0] && press.code != '0)
            begin
                key_queue.push_back(press);
                keys_predicted++;
            end
        end
    endtask

    // Offer one edge, with random idle cycles first, and return at the edge of its transfer.
    task automatic send_gap(input logic [ipd_pkg::TICK_W-1:0] gap);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        gap_ticks <= gap;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_edge(gap);
        edges_sent++;
    endtask

    // Send one full frame up to the check edge; the edge at break_at gets a random gap instead.
    task automatic send_frame(input logic [ipd_pkg::FRAME_W-1:0] word, input int break_at,
                              input logic [ipd_pkg::TICK_W-1:0] first_gap,
                              input logic [ipd_pkg::TICK_W-1:0] lead);
        logic [ipd_pkg::TICK_W-1:0] gap;
        for (int i = 0; i < int'(ipd_pkg::CHECK_EDGE); i++)
        begin
            if (i == 0)
                gap = first_gap;
            else if (i == 1)
                gap = lead;
            else
                gap = bit_gap(word[int'(ipd_pkg::CHECK_EDGE) - 1 - i]);
            if (i == break_at)
                gap = ipd_pkg::TICK_W'($urandom_range(0, TICK_MAX));
            send_gap(gap);
        end
    endtask

    task automatic send_command(input logic [ipd_pkg::CODE_W-1:0] cmd);
        send_frame(good_word(cmd), NO_BREAK, restart_gap(), leader_gap());
    endtask

    // Stop sending and wait until every predicted key press has arrived and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (key_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ipd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipd_pkg::TICK_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            ipd_pkg::REG_LEADER_MIN: cfg_now.leader_min = value;
            ipd_pkg::REG_LEADER_MAX: cfg_now.leader_max = value;
            ipd_pkg::REG_ZERO_LOW:   cfg_now.zero_low = value;
            ipd_pkg::REG_ZERO_HIGH:  cfg_now.zero_high = value;
            ipd_pkg::REG_ONE_LOW:    cfg_now.one_low = value;
            ipd_pkg::REG_ONE_HIGH:   cfg_now.one_high = value;
            ipd_pkg::REG_TIMEOUT:    cfg_now.timeout = value;
            ipd_pkg::REG_CUSTOMER:   cfg_now.customer = value;
            default:                 ;
        endcase
    endtask

    task automatic write_all(input ipd_pkg::ipd_cfg_t c);
        write_reg(ipd_pkg::REG_LEADER_MIN, c.leader_min);
        write_reg(ipd_pkg::REG_LEADER_MAX, c.leader_max);
        write_reg(ipd_pkg::REG_ZERO_LOW, c.zero_low);
        write_reg(ipd_pkg::REG_ZERO_HIGH, c.zero_high);
        write_reg(ipd_pkg::REG_ONE_LOW, c.one_low);
        write_reg(ipd_pkg::REG_ONE_HIGH, c.one_high);
        write_reg(ipd_pkg::REG_TIMEOUT, c.timeout);
        write_reg(ipd_pkg::REG_CUSTOMER, c.customer);
    endtask

    task automatic load_config(input ipd_pkg::ipd_cfg_t c);
        write_all(c);
        cfg_wr_en <= 1'b0;
    endtask

    // Every mapped key, an unmapped command, both command extremes and a zero command.
    task automatic test_key_codes();
        send_command(ipd_pkg::CODE_MENU);
        send_command(ipd_pkg::CODE_UP);
        send_command(ipd_pkg::CODE_DOWN);
        send_command(ipd_pkg::CODE_LEFT);
        send_command(ipd_pkg::CODE_RIGHT);
        send_command(ipd_pkg::CODE_ENTER);
        send_command(ipd_pkg::CODE_CANCEL);
        send_command(8'h01);
        send_command(8'hff);
        send_command(8'h00);
    endtask

    // Frames that fail the customer check or the complement check.
    task automatic test_frame_checks();
        logic [ipd_pkg::FRAME_W-1:0] word;
        word = good_word(ipd_pkg::CODE_ENTER);
        word[ipd_pkg::FRAME_W-1 -: ipd_pkg::TICK_W] =
            cfg_now.customer ^ (16'h1 << $urandom_range(0, ipd_pkg::TICK_W - 1));
        send_frame(word, NO_BREAK, restart_gap(), leader_gap());
        word = good_word(ipd_pkg::CODE_ENTER)
               ^ (32'h1 << $urandom_range(0, 2 * ipd_pkg::CODE_W - 1));
        send_frame(word, NO_BREAK, restart_gap(), leader_gap());
    endtask

    // Smallest and largest gaps, gaps on the edges of the leader and zero windows, and the timeout.
    task automatic test_gap_extremes();
        send_gap('0);
        send_gap(GAP_MAX);
        send_gap('0);
        send_gap(GAP_MAX);
        send_gap(cfg_now.leader_max + 1'b1);
        send_gap(GAP_MAX);
        send_gap(leader_gap());
        send_gap(cfg_now.zero_low);
        // The frame has just dropped, so a gap equal to the timeout still opens a new one.
        send_frame(good_word(ipd_pkg::CODE_UP), NO_BREAK, cfg_now.timeout, cfg_now.leader_min);
        send_frame(good_word(ipd_pkg::CODE_DOWN), NO_BREAK, restart_gap(), cfg_now.leader_max);
    endtask

    // A bad leader drops a frame, a random gap replaces one bit of another; reception recovers afterwards.
    task automatic test_restarts();
        send_frame(good_word(ipd_pkg::CODE_LEFT), NO_BREAK, restart_gap(),
                   cfg_now.leader_min - 1'b1);
        send_frame(good_word(ipd_pkg::CODE_LEFT), 17, restart_gap(), leader_gap());
        send_command(ipd_pkg::CODE_RIGHT);
    endtask

    // Zero and one windows that share some gaps.
    task automatic test_overlapping_windows();
        ipd_pkg::ipd_cfg_t c;
        settle();
        c = reset_config();
        c.one_low = c.zero_low + 16'd2;
        load_config(c);
        repeat (3)
            send_command(random_key_code());
    endtask

    // Writes to indexes past the last register change nothing.
    task automatic test_unknown_register();
        settle();
        write_all(reset_config());
        repeat (3)
            write_reg(ipd_pkg::CFG_IDX_W'($urandom_range(int'(ipd_pkg::REG_CUSTOMER) + 1,
                                                         (1 << ipd_pkg::CFG_IDX_W) - 1)),
                      ipd_pkg::TICK_W'($urandom_range(0, TICK_MAX)));
        cfg_wr_en <= 1'b0;
        send_command(ipd_pkg::CODE_MENU);
        send_command(ipd_pkg::CODE_CANCEL);
    endtask

    // All registers at zero, then all at their largest value.
    task automatic test_config_extremes();
        settle();
        load_config('0);
        send_gap('0);
        send_gap('0);
        send_gap(16'h1);
        send_gap(GAP_MAX);
        send_command(ipd_pkg::CODE_MENU);
        settle();
        load_config('1);
        send_gap(GAP_MAX);
        send_gap(GAP_MAX);
        send_gap('0);
        send_command(ipd_pkg::CODE_CANCEL);
    endtask

    // Keep counting past the check edge until the edge counter wraps; the edge after the
    // wrap opens a new frame without any timeout gap.
    task automatic test_counter_wrap();
        settle();
        load_config(reset_config());
        send_command(ipd_pkg::CODE_RIGHT);
        repeat (WRAP_EDGES)
            send_gap(bit_gap(1'($urandom_range(0, 1))));
        send_frame(good_word(ipd_pkg::CODE_MENU), NO_BREAK, bit_gap(1'b1), leader_gap());
    endtask

    // One random piece of traffic: mostly well-formed frames, some broken ones and some noise.
    task automatic send_random_unit();
        int                          pick;
        logic [ipd_pkg::CODE_W-1:0]  cmd;
        logic [ipd_pkg::FRAME_W-1:0] word;
        logic [ipd_pkg::TICK_W-1:0]  first;
        pick = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 1) != 0) ? random_key_code()
                                          : ipd_pkg::CODE_W'($urandom_range(0, 255));
        word = good_word(cmd);
        first = ($urandom_range(0, 9) < 7) ? restart_gap() : bit_gap(1'($urandom_range(0, 1)));
        if (pick < 60)
        begin
            send_frame(word, NO_BREAK, first, leader_gap());
        end
        else if (pick < 70)
        begin
            send_frame(word ^ (32'h1 << $urandom_range(0, ipd_pkg::FRAME_W - 1)), NO_BREAK,
                       first, leader_gap());
        end
        else if (pick < 85)
        begin
            send_frame(word, $urandom_range(1, int'(ipd_pkg::CHECK_EDGE) - 1), first,
                       leader_gap());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_gap(($urandom_range(0, 1) != 0)
                         ? ipd_pkg::TICK_W'($urandom_range(0, TICK_MAX))
                         : ipd_pkg::TICK_W'($urandom_range(0, 255)));
        end
        // Now and then a few more edges past the check edge.
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                send_gap(bit_gap(1'($urandom_range(0, 1))));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int first_edge;
        int first_key;
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_edge = edges_sent;
        first_key = keys_predicted;
        while (edges_sent - first_edge < PHASE_EDGES || keys_predicted - first_key < PHASE_KEYS)
        begin
            settle();
            load_config(random_config());
            repeat (UNITS_PER_SETTING)
                send_random_unit();
        end
    endtask

    initial
    begin
        cfg_now = reset_config();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_key_codes();
        test_frame_checks();
        test_gap_extremes();
        test_restarts();
        test_overlapping_windows();
        test_unknown_register();
        test_config_extremes();
        test_counter_wrap();
        test_random_traffic(13, 83);
        test_random_traffic(83, 13);
        test_random_traffic(0, 0);

        settle();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
